FILE: src/defr_pkg.sv
// Shared types and constants for the datapoint echo filter and router.
// No dependencies; every other file but defr_ifs.sv refers to this package by scoped names.
`timescale 1ns / 1ps

package defr_pkg;

   // Configuration port geometry: six 64-bit registers at 8-byte spacing
   localparam int unsigned CSR_DATA_W = 64;
   localparam int unsigned CSR_ADDR_W = 6;
   localparam int unsigned REG_IDX_W  = 3;

   // Register indexes (paddr[5:3])
   localparam logic [REG_IDX_W-1:0] REG_RELAY_MAP    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_RELAY_COUNT  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_BUTTON_MAP   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_BUTTON_COUNT = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_ECHO_WINDOW  = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_HAS_NEXT     = 3'd5;

   localparam logic [15:0] ECHO_WINDOW_RESET = 16'd700;

   // Input word function codes
   localparam logic [1:0] FUNC_TICK   = 2'd0;
   localparam logic [1:0] FUNC_WRITE  = 2'd1;
   localparam logic [1:0] FUNC_REPORT = 2'd2;

   // One input word
   typedef struct packed {
      logic [1:0] func;
      logic [7:0] dp_id;
      logic       is_bool;
      logic       has_value;
      logic [7:0] value_byte;
      logic       passive;
      logic       bulk_dump;
   } item_type;

   // One result word
   typedef struct packed {
      logic       relay_hit;
      logic [2:0] relay_index;
      logic [7:0] relay_value;
      logic       button_hit;
      logic [2:0] button_index;
      logic       echo_consumed;
      logic       forward;
      logic [7:0] write_dp;
      logic       write_value;
   } result_type;

   // Configuration register contents
   typedef struct packed {
      logic [63:0] relay_dp_map;
      logic [3:0]  relay_count;
      logic [63:0] button_dp_map;
      logic [3:0]  button_count;
      logic [15:0] echo_window_ms;
      logic        has_next_handler;
   } cfg_type;

   // Command from the pipeline to the echo table
   typedef struct packed {
      logic       fire;   // word leaves the input register this cycle
      logic       tick;
      logic       arm;
      logic       check;
      logic [7:0] dp_id;
   } echo_cmd_type;

endpackage

FILE: src/defr_ifs.sv
// Valid/ready stream interfaces for the request and response words.
// Field widths match defr_pkg::item_type and defr_pkg::result_type.
`timescale 1ns / 1ps

interface defr_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] dp_id;
   logic       is_bool;
   logic       has_value;
   logic [7:0] value_byte;
   logic       passive;
   logic       bulk_dump;

   modport source (output valid, func, dp_id, is_bool, has_value, value_byte, passive,
                   bulk_dump, input ready);
   modport sink   (input valid, func, dp_id, is_bool, has_value, value_byte, passive,
                   bulk_dump, output ready);
endinterface

interface defr_rsp_if;
   logic       valid;
   logic       ready;
   logic       relay_hit;
   logic [2:0] relay_index;
   logic [7:0] relay_value;
   logic       button_hit;
   logic [2:0] button_index;
   logic       echo_consumed;
   logic       forward;
   logic [7:0] write_dp;
   logic       write_value;

   modport source (output valid, relay_hit, relay_index, relay_value, button_hit,
                   button_index, echo_consumed, forward, write_dp, write_value,
                   input ready);
   modport sink   (input valid, relay_hit, relay_index, relay_value, button_hit,
                   button_index, echo_consumed, forward, write_dp, write_value,
                   output ready);
endinterface

FILE: src/defr_csr.sv
// APB-style configuration register file for the router.
// Depends on defr_pkg for register indexes and the cfg_type struct.
`timescale 1ns / 1ps

module defr_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [defr_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [defr_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [defr_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready,
   output defr_pkg::cfg_type                 cfg
);

   defr_pkg::cfg_type                 cfg_ff;
   defr_pkg::cfg_type                 cfg_in;
   logic [defr_pkg::REG_IDX_W-1:0]    reg_idx;
   logic                              wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[defr_pkg::CSR_ADDR_W-1:defr_pkg::CSR_ADDR_W-defr_pkg::REG_IDX_W];
   assign wr_en   = psel && penable && pwrite;
   assign cfg     = cfg_ff;

   // write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            defr_pkg::REG_RELAY_MAP:    cfg_in.relay_dp_map     = pwdata;
            defr_pkg::REG_RELAY_COUNT:  cfg_in.relay_count      = pwdata[3:0];
            defr_pkg::REG_BUTTON_MAP:   cfg_in.button_dp_map    = pwdata;
            defr_pkg::REG_BUTTON_COUNT: cfg_in.button_count     = pwdata[3:0];
            defr_pkg::REG_ECHO_WINDOW:  cfg_in.echo_window_ms   = pwdata[15:0];
            defr_pkg::REG_HAS_NEXT:     cfg_in.has_next_handler = pwdata[0];
            default: ;  // unmapped: write ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff                  <= '0;
         cfg_ff.echo_window_ms   <= defr_pkg::ECHO_WINDOW_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      unique case (reg_idx)
         defr_pkg::REG_RELAY_MAP:    prdata = cfg_ff.relay_dp_map;
         defr_pkg::REG_RELAY_COUNT:  prdata = {60'd0, cfg_ff.relay_count};
         defr_pkg::REG_BUTTON_MAP:   prdata = cfg_ff.button_dp_map;
         defr_pkg::REG_BUTTON_COUNT: prdata = {60'd0, cfg_ff.button_count};
         defr_pkg::REG_ECHO_WINDOW:  prdata = {48'd0, cfg_ff.echo_window_ms};
         defr_pkg::REG_HAS_NEXT:     prdata = {63'd0, cfg_ff.has_next_handler};
         default:                    prdata = '0;
      endcase
   end

endmodule

FILE: src/defr_echo_table.sv
// Millisecond counter and echo slot table: arming on local writes,
// echo lookup and clearing on reports. Depends on defr_pkg.
`timescale 1ns / 1ps

module defr_echo_table #(
   parameter int ECHO_SLOTS = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  defr_pkg::echo_cmd_type cmd,
   input  logic [15:0]            window_ms,
   output logic                   consumed
);

   localparam int LEVELS = (ECHO_SLOTS > 1) ? $clog2(ECHO_SLOTS) : 1;
   localparam int TREE_N = 1 << LEVELS;

   logic [31:0]       now_ms_ff, now_ms_in;
   logic [7:0]        ids_ff    [ECHO_SLOTS];
   logic [7:0]        ids_in    [ECHO_SLOTS];
   logic [31:0]       expiry_ff [ECHO_SLOTS];
   logic [31:0]       expiry_in [ECHO_SLOTS];

   logic              id_found;
   logic [LEVELS-1:0] id_idx;
   logic              live_found;
   logic [LEVELS-1:0] live_idx;
   logic [31:0]       tree_val [LEVELS+1][TREE_N];
   logic [LEVELS-1:0] tree_idx [LEVELS+1][TREE_N];
   logic [LEVELS-1:0] arm_slot;
   logic [31:0]       arm_expiry;

   // first slot holding the id, and first live slot holding it
   always_comb begin
      id_found   = 1'b0;
      id_idx     = '0;
      live_found = 1'b0;
      live_idx   = '0;
      for (int i = 0; i < ECHO_SLOTS; i++) begin
         if (!id_found && ids_ff[i] == cmd.dp_id) begin
            id_found = 1'b1;
            id_idx   = LEVELS'(i);
         end
         if (!live_found && ids_ff[i] == cmd.dp_id && expiry_ff[i] > now_ms_ff) begin
            live_found = 1'b1;
            live_idx   = LEVELS'(i);
         end
      end
   end

   // earliest expiry, ties to the lower slot; padding never wins a tie
   always_comb begin
      for (int l = 0; l <= LEVELS; l++) begin
         for (int n = 0; n < TREE_N; n++) begin
            tree_val[l][n] = '1;
            tree_idx[l][n] = LEVELS'(n);
         end
      end
      for (int n = 0; n < ECHO_SLOTS; n++) begin
         tree_val[0][n] = expiry_ff[n];
      end
      for (int l = 1; l <= LEVELS; l++) begin
         for (int n = 0; n < (TREE_N >> l); n++) begin
            if (tree_val[l-1][2*n+1] < tree_val[l-1][2*n]) begin
               tree_val[l][n] = tree_val[l-1][2*n+1];
               tree_idx[l][n] = tree_idx[l-1][2*n+1];
            end else begin
               tree_val[l][n] = tree_val[l-1][2*n];
               tree_idx[l][n] = tree_idx[l-1][2*n];
            end
         end
      end
   end

   assign arm_slot   = id_found ? id_idx : tree_idx[LEVELS][0];
   assign arm_expiry = now_ms_ff + {16'd0, window_ms};
   assign consumed   = cmd.check && live_found;

   // next state
   always_comb begin
      now_ms_in = now_ms_ff;
      ids_in    = ids_ff;
      expiry_in = expiry_ff;
      if (cmd.fire) begin
         if (cmd.tick) begin
            now_ms_in = now_ms_ff + 32'd1;
         end
         if (cmd.arm) begin
            ids_in[arm_slot]    = cmd.dp_id;
            expiry_in[arm_slot] = arm_expiry;
         end
         if (consumed) begin
            expiry_in[live_idx] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ms_ff <= '0;
         for (int i = 0; i < ECHO_SLOTS; i++) begin
            ids_ff[i]    <= '0;
            expiry_ff[i] <= '0;
         end
      end else begin
         now_ms_ff <= now_ms_in;
         ids_ff    <= ids_in;
         expiry_ff <= expiry_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_tick_advances: assert property (@(posedge clock) disable iff (reset)
      cmd.fire && cmd.tick |=> now_ms_ff == $past(now_ms_ff) + 32'd1)
      else $error("echo table: tick did not advance the counter");

   a_counter_holds: assert property (@(posedge clock) disable iff (reset)
      !(cmd.fire && cmd.tick) |=> now_ms_ff == $past(now_ms_ff))
      else $error("echo table: counter moved without a tick");

   a_echo_cleared: assert property (@(posedge clock) disable iff (reset)
      cmd.fire && consumed && !cmd.arm |=> expiry_ff[$past(live_idx)] == 32'd0)
      else $error("echo table: consumed slot still live");
`endif

endmodule

FILE: src/defr_router.sv
// Report routing: relay and button id matching and result word assembly.
// Depends on defr_pkg; the echo decision comes from defr_echo_table.
`timescale 1ns / 1ps

module defr_router #(
   parameter int MAX_RELAYS  = 8,
   parameter int MAX_BUTTONS = 8
) (
   input  defr_pkg::item_type   item,
   input  defr_pkg::cfg_type    cfg,
   input  logic                 echo_consumed,
   output defr_pkg::result_type result
);

   logic       relay_found;
   logic [2:0] relay_idx;
   logic       button_found;
   logic [2:0] button_idx;
   logic       relay_hit;
   logic       button_hit;
   logic       not_ours;

   // first configured relay with this id, below the count
   always_comb begin
      relay_found = 1'b0;
      relay_idx   = '0;
      for (int i = 0; i < MAX_RELAYS; i++) begin
         if (!relay_found && 4'(i) < cfg.relay_count &&
             cfg.relay_dp_map[8*i +: 8] != 8'd0 &&
             cfg.relay_dp_map[8*i +: 8] == item.dp_id) begin
            relay_found = 1'b1;
            relay_idx   = 3'(i);
         end
      end
   end

   // first configured button with this id, below the count
   always_comb begin
      button_found = 1'b0;
      button_idx   = '0;
      for (int i = 0; i < MAX_BUTTONS; i++) begin
         if (!button_found && 4'(i) < cfg.button_count &&
             cfg.button_dp_map[8*i +: 8] != 8'd0 &&
             cfg.button_dp_map[8*i +: 8] == item.dp_id) begin
            button_found = 1'b1;
            button_idx   = 3'(i);
         end
      end
   end

   assign not_ours   = !item.passive && !item.bulk_dump;
   assign relay_hit  = item.is_bool && item.has_value && relay_found;
   assign button_hit = not_ours && !echo_consumed && button_found;

   // result word per function code
   always_comb begin
      result = '0;
      case (item.func)
         defr_pkg::FUNC_WRITE: begin
            result.write_dp    = item.dp_id;
            result.write_value = (item.value_byte != 8'd0);
         end
         defr_pkg::FUNC_REPORT: begin
            result.relay_hit     = relay_hit;
            result.relay_index   = relay_hit ? relay_idx : 3'd0;
            result.relay_value   = relay_hit ? item.value_byte : 8'd0;
            result.button_hit    = button_hit;
            result.button_index  = button_hit ? button_idx : 3'd0;
            result.echo_consumed = echo_consumed;
            result.forward       = !relay_hit && !button_hit && cfg.has_next_handler;
         end
         default: ;  // tick and unused code: all-zero result
      endcase
   end

endmodule

FILE: src/datapoint_echo_filter_router_core.sv
// Top level of the datapoint echo filter and router.
// Uses defr_pkg, defr_req_if/defr_rsp_if, defr_csr, defr_echo_table, defr_router.
//
// Usage:
//  - req_if carries one word per tick, local write or datapoint report
//    (valid/ready); rsp_if returns exactly one result word for every request
//    word, in order, including ticks and the unused function code.
//  - csr_* is an APB-style port: six 64-bit registers at byte address 8*i.
//    Writes land at the access phase; pready is tied high. Write only while
//    no words are in flight.
//  - Path: an accepted word waits in the input register, and its result is
//    written to the output register, where rsp valid rises.
//  - Throughput: one word per cycle while rsp ready holds. The path that sets
//    the clock runs from the input register through the echo slot compares
//    into the result register; the earliest-expiry tree feeds the echo slots.
//  - Stall: a held result keeps the output register; one more word waits in
//    the input register, then req ready drops until rsp ready returns.
//  - Reset (synchronous): empties both registers, clears the millisecond
//    counter and all echo slots, and returns registers to their reset values.
`timescale 1ns / 1ps

module datapoint_echo_filter_router_core #(
   parameter int ECHO_SLOTS  = 4,
   parameter int MAX_RELAYS  = 8,
   parameter int MAX_BUTTONS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   defr_req_if.sink                          req_if,
   defr_rsp_if.source                        rsp_if,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [defr_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [defr_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [defr_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   defr_pkg::cfg_type      cfg;
   defr_pkg::item_type     item_ff, item_in;
   logic                   item_valid_ff, item_valid_in;
   defr_pkg::result_type   result_ff, result_in, route_result;
   logic                   rsp_valid_ff, rsp_valid_in;
   defr_pkg::echo_cmd_type echo_cmd;
   logic                   echo_consumed;
   logic                   out_free;
   logic                   advance;
   logic                   accept;

   defr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // handshake: output register frees when empty or taken
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign advance      = item_valid_ff && out_free;
   assign req_if.ready = !item_valid_ff || out_free;
   assign accept       = req_if.valid && req_if.ready;

   // echo table command for the word in the input register
   assign echo_cmd.fire  = advance;
   assign echo_cmd.tick  = item_ff.func == defr_pkg::FUNC_TICK;
   assign echo_cmd.arm   = item_ff.func == defr_pkg::FUNC_WRITE;
   assign echo_cmd.check = item_ff.func == defr_pkg::FUNC_REPORT &&
                           !item_ff.passive && !item_ff.bulk_dump;
   assign echo_cmd.dp_id = item_ff.dp_id;

   defr_echo_table #(
      .ECHO_SLOTS (ECHO_SLOTS)
   ) u_echo_table (
      .clock     (clock),
      .reset     (reset),
      .cmd       (echo_cmd),
      .window_ms (cfg.echo_window_ms),
      .consumed  (echo_consumed)
   );

   defr_router #(
      .MAX_RELAYS  (MAX_RELAYS),
      .MAX_BUTTONS (MAX_BUTTONS)
   ) u_router (
      .item          (item_ff),
      .cfg           (cfg),
      .echo_consumed (echo_consumed),
      .result        (route_result)
   );

   // input register next state
   always_comb begin
      item_valid_in = item_valid_ff;
      item_in       = item_ff;
      if (accept) begin
         item_valid_in      = 1'b1;
         item_in.func       = req_if.func;
         item_in.dp_id      = req_if.dp_id;
         item_in.is_bool    = req_if.is_bool;
         item_in.has_value  = req_if.has_value;
         item_in.value_byte = req_if.value_byte;
         item_in.passive    = req_if.passive;
         item_in.bulk_dump  = req_if.bulk_dump;
      end else if (advance) begin
         item_valid_in = 1'b0;
      end
   end

   // result register next state
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      result_in    = result_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         result_in    = route_result;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      result_ff <= result_in;
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.relay_hit     = result_ff.relay_hit;
   assign rsp_if.relay_index   = result_ff.relay_index;
   assign rsp_if.relay_value   = result_ff.relay_value;
   assign rsp_if.button_hit    = result_ff.button_hit;
   assign rsp_if.button_index  = result_ff.button_index;
   assign rsp_if.echo_consumed = result_ff.echo_consumed;
   assign rsp_if.forward       = result_ff.forward;
   assign rsp_if.write_dp      = result_ff.write_dp;
   assign rsp_if.write_value   = result_ff.write_value;

`ifndef NO_ASSERTIONS
   a_word_reaches_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("core: word left the input register but no result appeared");

   a_echo_blocks_press: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(result_ff.echo_consumed && result_ff.button_hit))
      else $error("core: echo and button press on the same report");

   a_forward_only_unhandled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.forward |-> !result_ff.relay_hit && !result_ff.button_hit)
      else $error("core: handled report also forwarded");
`endif

endmodule
